@@ rtl/owm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, phase codes, command codes, register indexes and defaults and
// the phase-end helper of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int unsigned CntW   = 10;
    localparam int unsigned CfgIdxW = 3;

    // commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // phases
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_RST_LOW = 4'd1;
    localparam logic [3:0] PH_RST_REL = 4'd2;
    localparam logic [3:0] PH_RST_REC = 4'd3;
    localparam logic [3:0] PH_WR_LOW  = 4'd4;
    localparam logic [3:0] PH_WR_REL  = 4'd5;
    localparam logic [3:0] PH_RD_LOW  = 4'd6;
    localparam logic [3:0] PH_RD_WAIT = 4'd7;
    localparam logic [3:0] PH_RD_TAIL = 4'd8;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_RESET_LOW   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRES_WAIT   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RESET_REC   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SLOT        = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SHORT_PULSE = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SAMPLE_WAIT = 3'd5;

    // register defaults
    localparam logic [CntW-1:0] DEF_RESET_LOW   = 10'd480;
    localparam logic [CntW-1:0] DEF_PRES_WAIT   = 10'd60;
    localparam logic [CntW-1:0] DEF_RESET_REC   = 10'd480;
    localparam logic [CntW-1:0] DEF_SLOT        = 10'd60;
    localparam logic [CntW-1:0] DEF_SHORT_PULSE = 10'd1;
    localparam logic [CntW-1:0] DEF_SAMPLE_WAIT = 10'd0;

    typedef struct packed {
        logic [CntW-1:0] reset_low_ticks;
        logic [CntW-1:0] presence_wait_ticks;
        logic [CntW-1:0] reset_recovery_ticks;
        logic [CntW-1:0] slot_ticks;
        logic [CntW-1:0] short_pulse_ticks;
        logic [CntW-1:0] sample_wait_ticks;
    } t_cfg;

    typedef struct packed {
        logic [3:0]      phase;
        logic [CntW-1:0] tick_count;
        logic [2:0]      bit_index;
        logic [7:0]      shift_byte;
        logic            presence_flag;
        logic [7:0]      last_read;
    } t_state;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
        logic       rejected;
    } t_result;

    // true when this tick ends a phase of len ticks (zero acts as one)
    function automatic logic phase_end(logic [CntW-1:0] cnt, logic [CntW:0] len);
        logic [CntW:0] nxt;
        nxt = {1'b0, cnt} + (CntW+1)'(1);
        return nxt >= len;
    endfunction

endpackage
`default_nettype wire

@@ rtl/owm_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owm_in_if
// Command channel: command, byte to send and sampled line level.
// ----------------------------------------------------------------------------
interface owm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       line_level;

    modport source (output valid, output command, output data_byte,
                    output line_level, input ready);
    modport sink   (input valid, input command, input data_byte,
                    input line_level, output ready);
endinterface
`default_nettype wire

@@ rtl/owm_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owm_out_if
// Result channel: line drive, status flags and last read byte.
// ----------------------------------------------------------------------------
interface owm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res,
                    output done_res, output presence, output read_byte,
                    output rejected, input ready);
    modport sink   (input valid, input drive_low, input busy_res,
                    input done_res, input presence, input read_byte,
                    input rejected, output ready);
endinterface
`default_nettype wire

@@ rtl/owm_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owm_step
// Next-state and result logic for one tick of the bus master sequencer.
// ----------------------------------------------------------------------------
module owm_step import owm_pkg::*; (
    input  t_state  i_state,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_res
);

    t_state     s;
    logic       drive;
    logic       done;
    logic       rej;
    logic       bit_val;
    logic       fin;
    logic [CntW:0] len;

    always_comb begin
        s     = i_state;
        drive = 1'b0;
        done  = 1'b0;
        rej   = 1'b0;
        fin   = 1'b0;
        len   = '0;

        // command start or reject
        if (i_item.command != CMD_TICK) begin
            if (i_state.phase != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                s.tick_count = '0;
                s.bit_index  = '0;
                unique case (i_item.command)
                    CMD_RESET: s.phase = PH_RST_LOW;
                    CMD_WRITE: begin
                        s.shift_byte = i_item.data_byte;
                        s.phase      = PH_WR_LOW;
                    end
                    default: begin
                        s.shift_byte = '0;
                        s.phase      = PH_RD_LOW;
                    end
                endcase
            end
        end

        bit_val = s.shift_byte[s.bit_index];

        // phase length for this tick
        case (s.phase)
            PH_RST_LOW: len = {1'b0, i_cfg.reset_low_ticks};
            PH_RST_REL: len = {1'b0, i_cfg.presence_wait_ticks};
            PH_RST_REC: len = {1'b0, i_cfg.reset_recovery_ticks} + (CntW+1)'(1);
            PH_WR_LOW:  len = {1'b0, bit_val ? i_cfg.short_pulse_ticks : i_cfg.slot_ticks};
            PH_WR_REL:  len = {1'b0, bit_val ? i_cfg.slot_ticks : i_cfg.short_pulse_ticks};
            PH_RD_LOW:  len = {1'b0, i_cfg.short_pulse_ticks};
            PH_RD_WAIT: len = {1'b0, i_cfg.sample_wait_ticks};
            PH_RD_TAIL: len = {1'b0, i_cfg.slot_ticks};
            default:    len = '0;
        endcase
        fin = phase_end(s.tick_count, len);

        unique case (s.phase)
            PH_RST_LOW, PH_RST_REL, PH_RST_REC, PH_WR_LOW, PH_WR_REL,
            PH_RD_LOW, PH_RD_WAIT, PH_RD_TAIL: begin
                // sample points on the first tick of the phase
                if (s.tick_count == '0) begin
                    if (s.phase == PH_RST_REC) begin
                        s.presence_flag = ~i_item.line_level;
                    end
                    if (s.phase == PH_RD_TAIL) begin
                        s.shift_byte[s.bit_index] = s.shift_byte[s.bit_index]
                                                    | i_item.line_level;
                    end
                end
                drive = (s.phase == PH_RST_LOW) || (s.phase == PH_WR_LOW)
                     || (s.phase == PH_RD_LOW);
                s.tick_count = fin ? '0 : s.tick_count + CntW'(1);
                if (fin) begin
                    case (s.phase)
                        PH_RST_LOW: s.phase = PH_RST_REL;
                        PH_RST_REL: s.phase = PH_RST_REC;
                        PH_RST_REC: begin
                            s.phase = PH_IDLE;
                            done    = 1'b1;
                        end
                        PH_WR_LOW: s.phase = PH_WR_REL;
                        PH_RD_LOW: s.phase = (i_cfg.sample_wait_ticks == '0)
                                             ? PH_RD_TAIL : PH_RD_WAIT;
                        PH_RD_WAIT: s.phase = PH_RD_TAIL;
                        default: begin
                            // end of a write or read slot
                            if (s.bit_index == 3'd7) begin
                                s.bit_index = '0;
                                s.phase     = PH_IDLE;
                                done        = 1'b1;
                                if (i_state.phase == PH_RD_TAIL) begin
                                    s.last_read = s.shift_byte;
                                end
                            end else begin
                                s.bit_index = s.bit_index + 3'd1;
                                s.phase     = (s.phase == PH_WR_REL) ? PH_WR_LOW
                                                                     : PH_RD_LOW;
                            end
                        end
                    endcase
                end
            end
            default: begin
                s.phase      = PH_IDLE;
                s.tick_count = '0;
            end
        endcase
    end

    assign o_state         = s;
    assign o_res.drive_low = drive;
    assign o_res.busy_res  = (s.phase != PH_IDLE);
    assign o_res.done_res  = done;
    assign o_res.presence  = s.presence_flag;
    assign o_res.read_byte = s.last_read;
    assign o_res.rejected  = rej;

endmodule
`default_nettype wire

@@ rtl/one_wire_bus_master_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_bus_master_top
// Tick-driven 1-Wire master: bus reset with presence detect, byte write and
// byte read, with programmable slot timing.
// ----------------------------------------------------------------------------
// Every transfer on the command channel is one 1 us tick and gives exactly one
// result transfer. Input ready is high, and one command is taken per clock,
// while the single output register, which decouples the channels, is empty or
// being taken. Sequencer state and result register update in the cycle of the
// transfer; its result shows in the cycle after. The user must write timing
// registers via the config port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top import owm_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CntW-1:0]     i_cfg_data,
    owm_in_if.sink                   i_in,
    owm_out_if.source                o_out
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   item;
    t_result n_res;
    t_result r_res;
    logic    r_out_valid;
    logic    in_xfer;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks      <= DEF_RESET_LOW;
            r_cfg.presence_wait_ticks  <= DEF_PRES_WAIT;
            r_cfg.reset_recovery_ticks <= DEF_RESET_REC;
            r_cfg.slot_ticks           <= DEF_SLOT;
            r_cfg.short_pulse_ticks    <= DEF_SHORT_PULSE;
            r_cfg.sample_wait_ticks    <= DEF_SAMPLE_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RESET_LOW:   r_cfg.reset_low_ticks      <= i_cfg_data;
                REG_PRES_WAIT:   r_cfg.presence_wait_ticks  <= i_cfg_data;
                REG_RESET_REC:   r_cfg.reset_recovery_ticks <= i_cfg_data;
                REG_SLOT:        r_cfg.slot_ticks           <= i_cfg_data;
                REG_SHORT_PULSE: r_cfg.short_pulse_ticks    <= i_cfg_data;
                REG_SAMPLE_WAIT: r_cfg.sample_wait_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign item.command    = i_in.command;
    assign item.data_byte  = i_in.data_byte;
    assign item.line_level = i_in.line_level;

    owm_step u_step (
        .i_state (r_state),
        .i_item  (item),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_res   (n_res)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.drive_low = r_res.drive_low;
    assign o_out.busy_res  = r_res.busy_res;
    assign o_out.done_res  = r_res.done_res;
    assign o_out.presence  = r_res.presence;
    assign o_out.read_byte = r_res.read_byte;
    assign o_out.rejected  = r_res.rejected;

    // a command during an operation is flagged as rejected
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in.command != CMD_TICK) && (r_state.phase != PH_IDLE)
        |=> o_out.rejected)
        else $error("busy command not rejected");

    // a finished operation leaves the master idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.done_res |-> !o_out.busy_res)
        else $error("done with busy set");

    // the line is only pulled low while an operation runs
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.drive_low |-> o_out.busy_res)
        else $error("drive low while idle");

    // the sequencer state moves only on an input transfer
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |=> $stable(r_state))
        else $error("state changed without transfer");

endmodule
`default_nettype wire

@@ verif/one_wire_bus_master_top_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_bus_master_top_test
// Self-checking bench for the tick-driven 1-Wire master. A directed plan
// covers idle ticks, commands refused while busy, zero-length timing
// registers, presence and read values and a long recovery count. A
// random part follows, run in phases with fresh timing registers each time.
// Each result transfer is compared field by field with its row's value or a
// bench cycle model. Both channels stall at random, except in random phases 1 and 4.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top_test;
    import owm_pkg::*;

    localparam int StallLimit = 1000;
    localparam int DrainCycles = 8;
    localparam logic [1:0] OP_NONE = 2'd0;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        t_item                item;
        int                   reps;
        bit                   typed;
        t_result              want;
        logic [CfgIdxW-1:0]   idx;
        logic [CntW-1:0]      val;
    } t_plan_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CntW-1:0]     cfg_data;

    owm_in_if  cmd_ch();
    owm_out_if res_ch();

    one_wire_bus_master_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (cmd_ch),
        .o_out      (res_ch)
    );

    // bus master model state
    t_cfg            timing;
    logic [3:0]      bus_phase;
    logic [1:0]      bus_op;
    logic [CntW-1:0] slot_cnt;
    logic [2:0]      bit_pos;
    logic [7:0]      shift_reg;
    logic            presence_seen;
    logic [7:0]      last_byte;

    t_result   pending_results[$];
    t_plan_row plan[$];
    int        errors = 0;
    int        stall_cycles = 0;
    bit        idle_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit span_done(int unsigned len);
        if (slot_cnt + 1 >= len) begin
            slot_cnt = '0;
            return 1'b1;
        end
        slot_cnt = slot_cnt + 1'b1;
        return 1'b0;
    endfunction

    function automatic bit next_bit(logic [3:0] restart);
        if (bit_pos == 3'd7) begin
            bit_pos = '0;
            bus_phase = PH_IDLE;
            bus_op = OP_NONE;
            return 1'b1;
        end
        bit_pos = bit_pos + 1'b1;
        bus_phase = restart;
        return 1'b0;
    endfunction

    function automatic t_result bus_master_tick(t_item it);
        t_result r;
        logic    b;
        r = '0;
        if (it.command != CMD_TICK) begin
            if (bus_phase != PH_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                bus_op = it.command;
                slot_cnt = '0;
                bit_pos = '0;
                case (it.command)
                    CMD_RESET: bus_phase = PH_RST_LOW;
                    CMD_WRITE: begin
                        shift_reg = it.data_byte;
                        bus_phase = PH_WR_LOW;
                    end
                    default: begin
                        shift_reg = '0;
                        bus_phase = PH_RD_LOW;
                    end
                endcase
            end
        end
        b = shift_reg[bit_pos];
        case (bus_phase)
            PH_RST_LOW: begin
                r.drive_low = 1'b1;
                if (span_done(timing.reset_low_ticks)) bus_phase = PH_RST_REL;
            end
            PH_RST_REL: begin
                if (span_done(timing.presence_wait_ticks)) bus_phase = PH_RST_REC;
            end
            PH_RST_REC: begin
                if (slot_cnt == '0) presence_seen = ~it.line_level;
                if (span_done(timing.reset_recovery_ticks + 1)) begin
                    bus_phase = PH_IDLE;
                    bus_op = OP_NONE;
                    r.done_res = 1'b1;
                end
            end
            PH_WR_LOW: begin
                r.drive_low = 1'b1;
                if (span_done(b ? timing.short_pulse_ticks : timing.slot_ticks))
                    bus_phase = PH_WR_REL;
            end
            PH_WR_REL: begin
                if (span_done(b ? timing.slot_ticks : timing.short_pulse_ticks)) begin
                    if (next_bit(PH_WR_LOW)) r.done_res = 1'b1;
                end
            end
            PH_RD_LOW: begin
                r.drive_low = 1'b1;
                if (span_done(timing.short_pulse_ticks))
                    bus_phase = (timing.sample_wait_ticks == '0) ? PH_RD_TAIL : PH_RD_WAIT;
            end
            PH_RD_WAIT: begin
                if (span_done(timing.sample_wait_ticks)) bus_phase = PH_RD_TAIL;
            end
            PH_RD_TAIL: begin
                if (slot_cnt == '0) shift_reg = shift_reg | (8'(it.line_level) << bit_pos);
                if (span_done(timing.slot_ticks)) begin
                    if (next_bit(PH_RD_LOW)) begin
                        last_byte = shift_reg;
                        r.done_res = 1'b1;
                    end
                end
            end
            default: begin
                bus_phase = PH_IDLE;
                bus_op = OP_NONE;
                slot_cnt = '0;
            end
        endcase
        r.busy_res = (bus_phase != PH_IDLE);
        r.presence = presence_seen;
        r.read_byte = last_byte;
        return r;
    endfunction

    function automatic void add_item(logic [1:0] cmd, logic [7:0] data, logic lvl,
                                     int reps, bit typed, t_result want);
        t_plan_row row;
        row.kind = ROW_ITEM;
        row.item = '{command: cmd, data_byte: data, line_level: lvl};
        row.reps = reps;
        row.typed = typed;
        row.want = want;
        row.idx = '0;
        row.val = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_reg(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] val);
        t_plan_row row;
        row.kind = ROW_REG;
        row.item = '0;
        row.reps = 0;
        row.typed = 1'b0;
        row.want = '0;
        row.idx = idx;
        row.val = val;
        plan.push_back(row);
    endfunction

    function automatic logic [CntW-1:0] draw_len();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CntW'($urandom_range(5, 12));
            default: return CntW'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic send_item(t_item it, bit typed, t_result want);
        int      gap;
        t_result pred;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            cmd_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= it.command;
        cmd_ch.data_byte <= it.data_byte;
        cmd_ch.line_level <= it.line_level;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        pred = bus_master_tick(it);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RESET_LOW:   timing.reset_low_ticks = val;
            REG_PRES_WAIT:   timing.presence_wait_ticks = val;
            REG_RESET_REC:   timing.reset_recovery_ticks = val;
            REG_SLOT:        timing.slot_ticks = val;
            REG_SHORT_PULSE: timing.short_pulse_ticks = val;
            REG_SAMPLE_WAIT: timing.sample_wait_ticks = val;
            default: ;
        endcase
    endtask

    // finish the running operation, then hold off until every result is back
    task automatic wait_bus_idle();
        t_item it;
        while (bus_phase != PH_IDLE) begin
            it.command = CMD_TICK;
            it.data_byte = 8'($urandom);
            it.line_level = 1'($urandom_range(0, 1));
            send_item(it, 1'b0, '0);
        end
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.drive_low = res_ch.drive_low;
        got.busy_res = res_ch.busy_res;
        got.done_res = res_ch.done_res;
        got.presence = res_ch.presence;
        got.read_byte = res_ch.read_byte;
        got.rejected = res_ch.rejected;
        if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
            return;
        end
        want = pending_results.pop_front();
        if (got.drive_low !== want.drive_low)
            report_mismatch($sformatf("drive_low %b, want %b", got.drive_low, want.drive_low));
        if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
            report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
        if (got.presence !== want.presence)
            report_mismatch($sformatf("presence %b, want %b", got.presence, want.presence));
        if (got.read_byte !== want.read_byte)
            report_mismatch($sformatf("read_byte %h, want %h", got.read_byte, want.read_byte));
        if (got.rejected !== want.rejected)
            report_mismatch($sformatf("rejected %b, want %b", got.rejected, want.rejected));
    endtask

    // result side
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = idle_on ? $urandom_range(0, 8) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            check_result();
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= StallLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_item it;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_TICK;
        cmd_ch.data_byte = '0;
        cmd_ch.line_level = 1'b0;

        timing = {DEF_RESET_LOW, DEF_PRES_WAIT, DEF_RESET_REC,
                  DEF_SLOT, DEF_SHORT_PULSE, DEF_SAMPLE_WAIT};
        bus_phase = PH_IDLE;
        bus_op = OP_NONE;
        slot_cnt = '0;
        bit_pos = '0;
        shift_reg = '0;
        presence_seen = 1'b0;
        last_byte = '0;

        // idle ticks, then commands refused while a write runs
        add_item(CMD_TICK,  8'h00, 1'b1, 1, 1'b1, {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0});
        add_item(CMD_TICK,  8'hFF, 1'b0, 1, 1'b1, {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0});
        add_reg(REG_SLOT, 10'd4);
        add_item(CMD_WRITE, 8'h00, 1'b1, 1, 1'b1, {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});
        add_item(CMD_RESET, 8'h00, 1'b1, 1, 1'b1, {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1});
        add_item(CMD_READ,  8'h00, 1'b0, 1, 1'b1, {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1});
        add_item(CMD_WRITE, 8'hFF, 1'b0, 1, 1'b1, {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1});
        // zero lengths behave as one tick
        add_reg(REG_RESET_LOW, '0);
        add_reg(REG_PRES_WAIT, '0);
        add_reg(REG_RESET_REC, '0);
        add_reg(REG_SLOT, '0);
        add_reg(REG_SHORT_PULSE, '0);
        add_reg(REG_SAMPLE_WAIT, '0);
        add_item(CMD_RESET, 8'h00, 1'b1, 1, 1'b1, {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});
        add_item(CMD_TICK,  8'h00, 1'b0, 1, 1'b1, {1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});
        add_item(CMD_TICK,  8'h00, 1'b0, 1, 1'b1, {1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0});
        add_item(CMD_TICK,  8'h00, 1'b1, 1, 1'b1, {1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0});
        add_item(CMD_WRITE, 8'hA5, 1'b0, 1, 1'b0, '0);
        add_item(CMD_TICK,  8'h00, 1'b1, 15, 1'b0, '0);
        add_item(CMD_READ,  8'h00, 1'b1, 1, 1'b0, '0);
        add_item(CMD_TICK,  8'hFF, 1'b1, 15, 1'b0, '0);
        // sampling wait in use, presence flips back to absent
        add_reg(REG_RESET_LOW, 10'd2);
        add_reg(REG_PRES_WAIT, 10'd3);
        add_reg(REG_RESET_REC, 10'd2);
        add_reg(REG_SLOT, 10'd2);
        add_reg(REG_SHORT_PULSE, 10'd2);
        add_reg(REG_SAMPLE_WAIT, 10'd3);
        add_item(CMD_RESET, 8'h00, 1'b1, 1, 1'b0, '0);
        add_item(CMD_TICK,  8'h00, 1'b1, 12, 1'b0, '0);
        add_item(CMD_READ,  8'h00, 1'b0, 1, 1'b0, '0);
        add_item(CMD_TICK,  8'h00, 1'b0, 60, 1'b0, '0);
        // long recovery count
        add_reg(REG_RESET_REC, 10'd100);
        add_item(CMD_RESET, 8'h00, 1'b0, 1, 1'b0, '0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_REG) begin
                wait_bus_idle();
                write_reg(plan[k].idx, plan[k].val);
            end else begin
                repeat (plan[k].reps) send_item(plan[k].item, plan[k].typed, plan[k].want);
            end
        end

        for (int p = 0; p < 5; p++) begin
            wait_bus_idle();
            idle_on = (p % 3 != 1);
            write_reg(REG_RESET_LOW, draw_len());
            write_reg(REG_PRES_WAIT, draw_len());
            write_reg(REG_RESET_REC, draw_len());
            write_reg(REG_SLOT, draw_len());
            write_reg(REG_SHORT_PULSE, draw_len());
            write_reg(REG_SAMPLE_WAIT, $urandom_range(0, 1) ? '0 : draw_len());
            repeat (60) begin
                it.command = CMD_TICK;
                if (bus_phase == PH_IDLE) begin
                    if ($urandom_range(0, 2) == 0)
                        it.command = 2'($urandom_range(CMD_RESET, CMD_READ));
                end else if ($urandom_range(0, 15) == 0) begin
                    it.command = 2'($urandom_range(CMD_RESET, CMD_READ));
                end
                it.data_byte = 8'($urandom);
                it.line_level = 1'($urandom_range(0, 1));
                send_item(it, 1'b0, '0);
            end
        end

        wait_bus_idle();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ one_wire_bus_master_top.f @@
rtl/owm_pkg.sv
rtl/owm_in_if.sv
rtl/owm_out_if.sv
rtl/owm_step.sv
rtl/one_wire_bus_master_top.sv
verif/one_wire_bus_master_top_test.sv
